// ===== sv/tnpe_pkg.sv =====
// ----------------------------------------------------------------------------
// Track nearest point encoder package
// Shared types and constants for the controller and the datapath.
// ----------------------------------------------------------------------------
package tnpe_pkg;

  localparam int TRACK_DEPTH  = 1024;
  localparam int IDX_W        = 10;
  localparam int SMP_W        = 10;
  localparam int CPOS_W       = 7;
  localparam int POS_W        = 32;
  localparam int CMD_W        = 3;
  localparam int THR_W        = 10;
  localparam int CFG_IDX_W    = 1;
  localparam int DIST_W       = 22;
  localparam int SQ_W         = 21;
  localparam int DIFF_W       = SMP_W + 1;
  localparam int COARSE_SHIFT = 3;
  localparam int BOUND_SHIFT  = 6;

  localparam logic [DIST_W-1:0] START_DIST = DIST_W'(32'h7FFF);
  localparam logic [THR_W-1:0]  LAP_LO_RST = THR_W'(256);
  localparam logic [THR_W-1:0]  LAP_HI_RST = THR_W'(768);

  localparam logic [CFG_IDX_W-1:0] CFG_LAP_LO = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAP_HI = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE    = 3'd0,
    CMD_LOAD_FINE = 3'd1,
    CMD_LOAD_CRS  = 3'd2,
    CMD_SET_POS   = 3'd3,
    CMD_CLR_LAPS  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_C_ISS,
    ST_C_DRN,
    ST_W1_ISS,
    ST_W1_DRN,
    ST_W2_ISS,
    ST_W2_DRN
  } state_t;

  typedef struct packed {
    logic wr_fine;
    logic wr_coarse;
    logic set_pos;
    logic clr_laps;
    logic start;
    logic issue;
    logic bound;
    logic start_fine;
    logic finish;
  } ctl_t;

  typedef struct packed {
    logic last;
    logic empty;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/tnpe_ctrl.sv =====
// ----------------------------------------------------------------------------
// Track nearest point encoder controller
// Decodes commands and sequences the coarse and two window passes.
// ----------------------------------------------------------------------------
module tnpe_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tnpe_pkg::CMD_W-1:0]   in_cmd,
  input  tnpe_pkg::sts_t               sts,
  output tnpe_pkg::ctl_t               ctl
);

  tnpe_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tnpe_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      tnpe_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (tnpe_pkg::cmd_t'(in_cmd))
            tnpe_pkg::CMD_SAMPLE: begin
              ctl.start = 1'b1;
              state_nxt = tnpe_pkg::ST_C_ISS;
            end
            tnpe_pkg::CMD_LOAD_FINE: ctl.wr_fine   = 1'b1;
            tnpe_pkg::CMD_LOAD_CRS:  ctl.wr_coarse = 1'b1;
            tnpe_pkg::CMD_SET_POS:   ctl.set_pos   = 1'b1;
            tnpe_pkg::CMD_CLR_LAPS:  ctl.clr_laps  = 1'b1;
            default: ;
          endcase
        end
      end
      tnpe_pkg::ST_C_ISS: begin
        ctl.issue = 1'b1;
        if (sts.last) state_nxt = tnpe_pkg::ST_C_DRN;
      end
      tnpe_pkg::ST_C_DRN: begin
        if (sts.empty) begin
          ctl.bound = 1'b1;
          state_nxt = tnpe_pkg::ST_W1_ISS;
        end
      end
      tnpe_pkg::ST_W1_ISS: begin
        ctl.issue = 1'b1;
        if (sts.last) state_nxt = tnpe_pkg::ST_W1_DRN;
      end
      tnpe_pkg::ST_W1_DRN: begin
        if (sts.empty) begin
          ctl.start_fine = 1'b1;
          state_nxt      = tnpe_pkg::ST_W2_ISS;
        end
      end
      tnpe_pkg::ST_W2_ISS: begin
        ctl.issue = 1'b1;
        if (sts.last) state_nxt = tnpe_pkg::ST_W2_DRN;
      end
      tnpe_pkg::ST_W2_DRN: begin
        if (sts.empty && sts.out_free) begin
          ctl.finish = 1'b1;
          state_nxt  = tnpe_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tnpe_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== sv/tnpe_dp.sv =====
// ----------------------------------------------------------------------------
// Track nearest point encoder datapath
// Table memories, distance pipeline, best tracking, laps and output register.
// ----------------------------------------------------------------------------
module tnpe_dp #(
  parameter int COARSE_DEPTH = 32,
  parameter int COARSE_STEP  = 32,
  parameter int FINE_STEP    = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tnpe_pkg::ctl_t                    ctl,
  output tnpe_pkg::sts_t                    sts,
  input  logic [tnpe_pkg::IDX_W-1:0]        in_entry_index,
  input  logic [tnpe_pkg::SMP_W-1:0]        in_sample_a,
  input  logic [tnpe_pkg::SMP_W-1:0]        in_sample_b,
  input  logic [tnpe_pkg::IDX_W-1:0]        in_coarse_track_pos,
  input  logic signed [tnpe_pkg::POS_W-1:0] in_new_position,
  input  logic                              cfg_we,
  input  logic [tnpe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tnpe_pkg::THR_W-1:0]        cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [tnpe_pkg::POS_W-1:0] out_position,
  output logic [tnpe_pkg::IDX_W-1:0]        out_track_index
);

  localparam int CA_W  = (COARSE_DEPTH > 1) ? $clog2(COARSE_DEPTH) : 1;
  localparam int OFF_W = $clog2(COARSE_STEP + FINE_STEP + 1) + 1;
  localparam int IW    = tnpe_pkg::IDX_W;
  localparam int SW    = tnpe_pkg::SMP_W;
  localparam int CW    = tnpe_pkg::CPOS_W;
  localparam int DW    = tnpe_pkg::DIFF_W;
  localparam int PW    = tnpe_pkg::POS_W;

  logic [SW-1:0] fine_a_mem [tnpe_pkg::TRACK_DEPTH];
  logic [SW-1:0] fine_b_mem [tnpe_pkg::TRACK_DEPTH];
  logic [CW-1:0] crs_a_mem  [COARSE_DEPTH];
  logic [CW-1:0] crs_b_mem  [COARSE_DEPTH];
  logic [IW-1:0] crs_p_mem  [COARSE_DEPTH];

  logic [SW-1:0] fa_rd_r, fb_rd_r;
  logic [CW-1:0] ca_rd_r, cb_rd_r;
  logic [IW-1:0] cp_rd_r;

  logic [SW-1:0] a_r, b_r;
  logic          coarse_mode_r;
  logic          fine_mode_r;
  logic [CA_W-1:0] cnt_r;
  logic signed [OFF_W-1:0] off_r, off_raw, off_nxt, span, stride;
  logic [IW-1:0] centre_r, idx;

  logic          v1_r, v2_r;
  logic [IW-1:0] tag1_r, tag2_r;
  logic [tnpe_pkg::SQ_W-1:0] sqa_r, sqb_r;
  logic signed [DW-1:0] ea, eb;
  logic signed [2*DW-1:0] pa, pb;
  logic [tnpe_pkg::DIST_W-1:0] dist_sum, best_r;
  logic [IW-1:0] found_r;

  logic [tnpe_pkg::THR_W-1:0] thr_lo_r, thr_hi_r;
  logic signed [PW-1:0] lap_r, lap_nxt, pos_adj;
  logic signed [IW:0] prev_r, n_s, lo_s, hi_s;

  logic [CA_W-1:0] crs_slot;
  assign crs_slot = CA_W'(in_entry_index);

  // Memories
  always_ff @(posedge clk) begin
    if (ctl.wr_fine) begin
      fine_a_mem[in_entry_index] <= in_sample_a;
      fine_b_mem[in_entry_index] <= in_sample_b;
    end
    if (ctl.wr_coarse && (32'(in_entry_index) < COARSE_DEPTH)) begin
      crs_a_mem[crs_slot] <= in_sample_a[CW-1:0];
      crs_b_mem[crs_slot] <= in_sample_b[CW-1:0];
      crs_p_mem[crs_slot] <= in_coarse_track_pos;
    end
    fa_rd_r <= fine_a_mem[idx];
    fb_rd_r <= fine_b_mem[idx];
    ca_rd_r <= crs_a_mem[cnt_r];
    cb_rd_r <= crs_b_mem[cnt_r];
    cp_rd_r <= crs_p_mem[cnt_r];
  end

  // Scan address generation
  assign idx     = centre_r + IW'(off_r);
  assign span    = fine_mode_r ? OFF_W'(FINE_STEP) : OFF_W'(COARSE_STEP);
  assign stride  = fine_mode_r ? OFF_W'(1) : OFF_W'(FINE_STEP);
  assign off_raw = off_r + stride;
  assign off_nxt = (off_r < 0 && off_raw >= 0) ? '0 : off_raw;

  always_comb begin
    sts.empty    = !v1_r && !v2_r;
    sts.out_free = !out_valid || out_ready;
    if (coarse_mode_r) begin
      sts.last = (cnt_r == CA_W'(COARSE_DEPTH - 1));
    end else begin
      sts.last = (off_raw >= span);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_r <= in_sample_a;
      b_r <= in_sample_b;
      cnt_r <= '0;
    end else if (ctl.issue && coarse_mode_r) begin
      cnt_r <= cnt_r + CA_W'(1);
    end
    if (ctl.bound) begin
      centre_r <= found_r;
      off_r    <= -OFF_W'(COARSE_STEP);
    end else if (ctl.start_fine) begin
      centre_r <= found_r;
      off_r    <= -OFF_W'(FINE_STEP);
    end else if (ctl.issue && !coarse_mode_r) begin
      off_r <= off_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coarse_mode_r <= 1'b0;
      fine_mode_r   <= 1'b0;
      v1_r          <= 1'b0;
      v2_r          <= 1'b0;
    end else begin
      if (ctl.start) begin
        coarse_mode_r <= 1'b1;
        fine_mode_r   <= 1'b0;
      end else if (ctl.bound) begin
        coarse_mode_r <= 1'b0;
      end else if (ctl.start_fine) begin
        fine_mode_r <= 1'b1;
      end
      v1_r <= ctl.issue;
      v2_r <= v1_r;
    end
  end

  // Distance pipeline
  always_comb begin
    if (coarse_mode_r) begin
      ea = $signed(DW'(a_r >> tnpe_pkg::COARSE_SHIFT)) - $signed(DW'(ca_rd_r));
      eb = $signed(DW'(b_r >> tnpe_pkg::COARSE_SHIFT)) - $signed(DW'(cb_rd_r));
    end else begin
      ea = $signed({1'b0, a_r}) - $signed({1'b0, fa_rd_r});
      eb = $signed({1'b0, b_r}) - $signed({1'b0, fb_rd_r});
    end
    pa       = ea * ea;
    pb       = eb * eb;
    dist_sum = tnpe_pkg::DIST_W'(sqa_r) + tnpe_pkg::DIST_W'(sqb_r);
  end

  always_ff @(posedge clk) begin
    tag1_r <= idx;
    tag2_r <= coarse_mode_r ? cp_rd_r : tag1_r;
    sqa_r  <= pa[tnpe_pkg::SQ_W-1:0];
    sqb_r  <= pb[tnpe_pkg::SQ_W-1:0];
    if (ctl.start) begin
      best_r  <= tnpe_pkg::START_DIST;
      found_r <= '0;
    end else if (ctl.bound) begin
      best_r <= (best_r + tnpe_pkg::DIST_W'(1)) << tnpe_pkg::BOUND_SHIFT;
    end else if (v2_r && (dist_sum < best_r)) begin
      best_r  <= dist_sum;
      found_r <= tag2_r;
    end
  end

  // Laps, thresholds and output
  assign n_s     = $signed({1'b0, found_r});
  assign lo_s    = $signed({1'b0, thr_lo_r});
  assign hi_s    = $signed({1'b0, thr_hi_r});
  assign pos_adj = in_new_position + (in_new_position[PW-1] ? PW'(tnpe_pkg::TRACK_DEPTH - 1) : '0);

  always_comb begin
    lap_nxt = lap_r;
    if (prev_r > hi_s) begin
      if (n_s < lo_s) lap_nxt = lap_r + PW'(1);
    end else if (prev_r < lo_s) begin
      if (n_s > hi_s) lap_nxt = lap_r - PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_lo_r  <= tnpe_pkg::LAP_LO_RST;
      thr_hi_r  <= tnpe_pkg::LAP_HI_RST;
      lap_r     <= '0;
      prev_r    <= '1;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == tnpe_pkg::CFG_LAP_LO) thr_lo_r <= cfg_data;
        if (cfg_index == tnpe_pkg::CFG_LAP_HI) thr_hi_r <= cfg_data;
      end
      if (ctl.set_pos) begin
        lap_r <= pos_adj >>> IW;
      end else if (ctl.clr_laps) begin
        lap_r <= '0;
      end else if (ctl.finish) begin
        lap_r  <= lap_nxt;
        prev_r <= n_s;
      end
      if (ctl.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      out_position    <= (lap_nxt <<< IW) | $signed(PW'(found_r));
      out_track_index <= found_r;
    end
  end

endmodule

// ===== sv/track_nearest_point_encoder.sv =====
// ----------------------------------------------------------------------------
// Track nearest point encoder
// Each sample runs a coarse pass and two window passes through one shared
// table-read and distance unit; no new command is accepted until the sample
// finishes, which waits while out_ready holds off the previous result.
// Load, set and clear commands give no result. Synchronous active-low reset
// clears laps, thresholds and control; tables hold undefined data.
// ----------------------------------------------------------------------------
module track_nearest_point_encoder #(
  parameter int COARSE_DEPTH = 32,
  parameter int COARSE_STEP  = 32,
  parameter int FINE_STEP    = 4
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [tnpe_pkg::CMD_W-1:0]            in_cmd,
  input  logic [tnpe_pkg::IDX_W-1:0]            in_entry_index,
  input  logic [tnpe_pkg::SMP_W-1:0]            in_sample_a,
  input  logic [tnpe_pkg::SMP_W-1:0]            in_sample_b,
  input  logic [tnpe_pkg::IDX_W-1:0]            in_coarse_track_pos,
  input  logic signed [tnpe_pkg::POS_W-1:0]     in_new_position,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [tnpe_pkg::POS_W-1:0]     out_position,
  output logic [tnpe_pkg::IDX_W-1:0]            out_track_index,
  input  logic                                  cfg_we,
  input  logic [tnpe_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tnpe_pkg::THR_W-1:0]            cfg_data
);

  tnpe_pkg::ctl_t ctl;
  tnpe_pkg::sts_t sts;

  tnpe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_cmd),
    .sts      (sts),
    .ctl      (ctl)
  );

  tnpe_dp #(
    .COARSE_DEPTH (COARSE_DEPTH),
    .COARSE_STEP  (COARSE_STEP),
    .FINE_STEP    (FINE_STEP)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctl                 (ctl),
    .sts                 (sts),
    .in_entry_index      (in_entry_index),
    .in_sample_a         (in_sample_a),
    .in_sample_b         (in_sample_b),
    .in_coarse_track_pos (in_coarse_track_pos),
    .in_new_position     (in_new_position),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_position        (out_position),
    .out_track_index     (out_track_index)
  );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Track nearest point encoder testbench
// Loads a smooth circular reference track, then drives directed and random
// commands (samples walking the track, noise, table reloads, position
// set/clear, unused codes) under several lap threshold settings. A
// scoreboard predicts each result and checks it field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int TRACK_DEPTH  = tnpe_pkg::TRACK_DEPTH;
  localparam int SMP_W        = tnpe_pkg::SMP_W;
  localparam int IDX_W        = tnpe_pkg::IDX_W;
  localparam int CPOS_W       = tnpe_pkg::CPOS_W;
  localparam int CMD_W        = tnpe_pkg::CMD_W;
  localparam int POS_W        = tnpe_pkg::POS_W;
  localparam int THR_W        = tnpe_pkg::THR_W;
  localparam int CFG_IDX_W    = tnpe_pkg::CFG_IDX_W;
  localparam int COARSE_SHIFT = tnpe_pkg::COARSE_SHIFT;
  localparam int BOUND_SHIFT  = tnpe_pkg::BOUND_SHIFT;

  localparam int NUM_CRS  = 32;
  localparam int CRS_STEP = 32;
  localparam int FN_STEP  = 4;
  localparam int SETTLE   = 80;

  class track_scoreboard;
    bit [SMP_W-1:0]  fine_a [TRACK_DEPTH];
    bit [SMP_W-1:0]  fine_b [TRACK_DEPTH];
    bit [CPOS_W-1:0] crs_a [NUM_CRS];
    bit [CPOS_W-1:0] crs_b [NUM_CRS];
    bit [IDX_W-1:0]  crs_pos [NUM_CRS];
    int laps;
    int last_idx;
    int lap_lo;
    int lap_hi;
    int exp_pos [$];
    int exp_idx [$];
    int n_results;

    function new();
      laps = 0;
      last_idx = -1;
      lap_lo = 256;
      lap_hi = 768;
      n_results = 0;
    endfunction

    function int sq(int ea, int eb);
      return ea * ea + eb * eb;
    endfunction

    function int scan_window(int centre, int span, int stride, int a, int b,
                             inout int best, input int found);
      int o;
      int off;
      int idx;
      int d;
      o = -span;
      while (o < span) begin
        off = o;
        if (o >= 0 && o - stride < 0 && o != 0) begin
          o = 0;
          off = 0;
        end
        idx = (centre + off) % TRACK_DEPTH;
        if (idx < 0) idx += TRACK_DEPTH;
        d = sq(a - int'(fine_a[idx]), b - int'(fine_b[idx]));
        if (d < best) begin
          best = d;
          found = idx;
        end
        o += stride;
      end
      return found;
    endfunction

    function void note_item(logic [CMD_W-1:0] cmd, bit [IDX_W-1:0] slot,
                            bit [SMP_W-1:0] sa, bit [SMP_W-1:0] sb,
                            bit [IDX_W-1:0] cpos, int np);
      int best;
      int n;
      int d;
      case (cmd)
        tnpe_pkg::CMD_LOAD_FINE: begin
          fine_a[slot] = sa;
          fine_b[slot] = sb;
        end
        tnpe_pkg::CMD_LOAD_CRS: begin
          if (slot < NUM_CRS) begin
            crs_a[slot] = sa[CPOS_W-1:0];
            crs_b[slot] = sb[CPOS_W-1:0];
            crs_pos[slot] = cpos;
          end
        end
        tnpe_pkg::CMD_SET_POS: laps = np / TRACK_DEPTH;
        tnpe_pkg::CMD_CLR_LAPS: laps = 0;
        tnpe_pkg::CMD_SAMPLE: begin
          best = 32'h7FFF;
          n = 0;
          for (int k = 0; k < NUM_CRS; k++) begin
            d = sq(int'(sa >> COARSE_SHIFT) - int'(crs_a[k]),
                   int'(sb >> COARSE_SHIFT) - int'(crs_b[k]));
            if (d < best) begin
              best = d;
              n = crs_pos[k];
            end
          end
          best = (best + 1) << BOUND_SHIFT;
          n = scan_window(n, CRS_STEP, FN_STEP, sa, sb, best, n);
          n = scan_window(n, FN_STEP, 1, sa, sb, best, n);
          if (last_idx > lap_hi) begin
            if (n < lap_lo) laps += 1;
          end else if (last_idx < lap_lo) begin
            if (n > lap_hi) laps -= 1;
          end
          last_idx = n;
          exp_pos.push_back(laps * TRACK_DEPTH + n);
          exp_idx.push_back(n);
        end
        default: ;
      endcase
    endfunction

    function string check_result(int pos, bit [IDX_W-1:0] idx);
      int ep;
      int ei;
      if (exp_pos.size() == 0) return "result item with nothing expected";
      ep = exp_pos.pop_front();
      ei = exp_idx.pop_front();
      n_results++;
      if (pos != ep || int'(idx) != ei)
        return $sformatf("result %0d: position %0d/%0d index %0d/%0d (got/exp)",
                         n_results, pos, ep, idx, ei);
      return "";
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [CMD_W-1:0] in_cmd;
  logic [IDX_W-1:0] in_entry_index;
  logic [SMP_W-1:0] in_sample_a;
  logic [SMP_W-1:0] in_sample_b;
  logic [IDX_W-1:0] in_coarse_track_pos;
  logic signed [POS_W-1:0] in_new_position;
  logic out_valid;
  logic out_ready;
  logic signed [POS_W-1:0] out_position;
  logic [IDX_W-1:0] out_track_index;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [THR_W-1:0] cfg_data;

  track_scoreboard sb;
  int errors;
  int hold_cycles;
  int n_items;
  int n_samples;
  int walk;

  track_nearest_point_encoder u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("timeout");
    $display("TEST FAILED");
    $finish;
  end

  task automatic report(string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    string msg;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        msg = sb.check_result(out_position, out_track_index);
        if (msg != "") report(msg);
      end
      if (in_valid && in_ready) begin
        sb.note_item(in_cmd, in_entry_index, in_sample_a, in_sample_b,
                     in_coarse_track_pos, in_new_position);
        n_items++;
        if (in_cmd == tnpe_pkg::CMD_SAMPLE) n_samples++;
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready = 1'b0;
      end else begin
        out_ready = ($urandom_range(0, 99) < 75) || ($urandom_range(0, 9) == 0);
        if ($urandom_range(0, 99) == 0) hold_cycles = $urandom_range(10, 40);
      end
    end
  end

  task automatic send(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] slot,
                      logic [SMP_W-1:0] sa, logic [SMP_W-1:0] sbv,
                      logic [IDX_W-1:0] cpos, logic signed [POS_W-1:0] np);
    int g;
    in_valid = 1'b1;
    in_cmd = cmd;
    in_entry_index = slot;
    in_sample_a = sa;
    in_sample_b = sbv;
    in_coarse_track_pos = cpos;
    in_new_position = np;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    g = gap_len();
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic sample(int sa, int sbv);
    send(tnpe_pkg::CMD_SAMPLE, IDX_W'($urandom), SMP_W'(sa), SMP_W'(sbv),
         IDX_W'($urandom), $urandom);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.exp_pos.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_thr(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = THR_W'(val);
    if (idx == tnpe_pkg::CFG_LAP_LO) sb.lap_lo = val;
    else sb.lap_hi = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic int clip(int v);
    return v < 0 ? 0 : (v > 1023 ? 1023 : v);
  endfunction

  task automatic walk_sample();
    int i;
    int noise;
    walk = (walk + $urandom_range(0, 80) - 40 + TRACK_DEPTH) % TRACK_DEPTH;
    i = walk;
    noise = $urandom_range(0, 1) ? $urandom_range(0, 6) - 3 : 0;
    sample(clip(sb.fine_a[i] + noise), clip(sb.fine_b[i] - noise));
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 56) walk_sample();
    else if (r < 80) sample($urandom_range(0, 1023), $urandom_range(0, 1023));
    else if (r < 85)
      send(tnpe_pkg::CMD_LOAD_FINE, IDX_W'($urandom), SMP_W'($urandom), SMP_W'($urandom),
           IDX_W'($urandom), $urandom);
    else if (r < 88)
      send(tnpe_pkg::CMD_LOAD_CRS, IDX_W'($urandom_range(0, 63)), SMP_W'($urandom),
           SMP_W'($urandom), IDX_W'($urandom), $urandom);
    else if (r < 93)
      send(tnpe_pkg::CMD_SET_POS, IDX_W'($urandom), SMP_W'($urandom), SMP_W'($urandom),
           IDX_W'($urandom), $urandom);
    else if (r < 96)
      send(tnpe_pkg::CMD_CLR_LAPS, IDX_W'($urandom), SMP_W'($urandom), SMP_W'($urandom),
           IDX_W'($urandom), $urandom);
    else
      send(CMD_W'($urandom_range(5, 7)), IDX_W'($urandom), SMP_W'($urandom),
           SMP_W'($urandom), IDX_W'($urandom), $urandom);
  endtask

  initial begin
    int va;
    int vb;
    sb = new();
    errors = 0;
    hold_cycles = 0;
    n_items = 0;
    n_samples = 0;
    walk = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = tnpe_pkg::CMD_SAMPLE;
    in_entry_index = '0;
    in_sample_a = '0;
    in_sample_b = '0;
    in_coarse_track_pos = '0;
    in_new_position = '0;
    cfg_we = 1'b0;
    cfg_index = tnpe_pkg::CFG_LAP_LO;
    cfg_data = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int i = 0; i < TRACK_DEPTH; i++) begin
      va = clip(512 + $rtoi(480.0 * $cos(6.2831853 * i / TRACK_DEPTH)));
      vb = clip(512 + $rtoi(480.0 * $sin(6.2831853 * i / TRACK_DEPTH)));
      send(tnpe_pkg::CMD_LOAD_FINE, IDX_W'(i), SMP_W'(va), SMP_W'(vb), '0, '0);
    end
    for (int k = 0; k < NUM_CRS; k++)
      send(tnpe_pkg::CMD_LOAD_CRS, IDX_W'(k), SMP_W'(sb.fine_a[k * 32] >> COARSE_SHIFT),
           SMP_W'(sb.fine_b[k * 32] >> COARSE_SHIFT), IDX_W'(k * 32), '0);

    // first sample lands above the high threshold
    sample(sb.fine_a[900], sb.fine_b[900]);
    sample(sb.fine_a[100], sb.fine_b[100]);
    sample(0, 0);
    sample(1023, 1023);
    sample(0, 1023);
    sample(1023, 0);
    sample(sb.fine_a[1023], sb.fine_b[1023]);
    sample(sb.fine_a[0], sb.fine_b[0]);
    send(tnpe_pkg::CMD_LOAD_CRS, IDX_W'(40), 10'h3FF, 10'h3FF, 10'h3FF, '0);
    send(tnpe_pkg::CMD_SET_POS, '0, '0, '0, '0, 32'sh7FFFFFFF);
    sample(sb.fine_a[500], sb.fine_b[500]);
    send(tnpe_pkg::CMD_SET_POS, '0, '0, '0, '0, 32'sh80000000);
    sample(sb.fine_a[10], sb.fine_b[10]);
    send(tnpe_pkg::CMD_SET_POS, '0, '0, '0, '0, -32'sd1500);
    sample(sb.fine_a[990], sb.fine_b[990]);
    send(tnpe_pkg::CMD_CLR_LAPS, '0, '0, '0, '0, '0);
    send(CMD_W'(5), '0, '0, '0, '0, '0);
    send(CMD_W'(7), 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, '1);
    sample(sb.fine_a[300], sb.fine_b[300]);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_thr(tnpe_pkg::CFG_LAP_LO, 256);
          write_thr(tnpe_pkg::CFG_LAP_HI, 768);
        end
        1: begin
          write_thr(tnpe_pkg::CFG_LAP_LO, 0);
          write_thr(tnpe_pkg::CFG_LAP_HI, 1023);
        end
        2: begin
          write_thr(tnpe_pkg::CFG_LAP_LO, 1023);
          write_thr(tnpe_pkg::CFG_LAP_HI, 0);
        end
        default: begin
          write_thr(tnpe_pkg::CFG_LAP_LO, $urandom_range(100, 400));
          write_thr(tnpe_pkg::CFG_LAP_HI, $urandom_range(600, 900));
        end
      endcase
      if (ph == 1) hold_cycles = 600;
      repeat (180) random_item();
      drain();
    end

    $display("covered %0d items (%0d samples), %0d results checked, 4 threshold settings",
             n_items, n_samples, sb.n_results);
    if (errors == 0 && sb.exp_pos.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, sb.exp_pos.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tnpe_pkg.sv
sv/tnpe_ctrl.sv
sv/tnpe_dp.sv
sv/track_nearest_point_encoder.sv
verif/tb_top.sv
